FILE: design/pcfh_pkg.sv
// pcfh_pkg: shared types, constants and class filter for the post code history
// no dependencies
`timescale 1ns / 1ps
package pcfh_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned LimW = 5;
  localparam int unsigned MaxOut = 16;

  localparam logic OpCapture = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic        capture;
    logic        read_start;
    logic        read_step;
  } pcfh_cmd_t;

  typedef struct packed {
    logic        pass;
    logic        read_empty;
    logic        read_final;
  } pcfh_status_t;

  function automatic logic in_set_a(input logic [15:0] v);
    logic hit;
    hit = 1'b0;
    unique case (v)
      16'h0ACE, 16'h0ACF, 16'hBAAB, 16'hBAAC, 16'hBAAD, 16'hE0B5, 16'hE0B6, 16'hE0BC,
      16'hE0BD, 16'hB1C0, 16'hB2C0, 16'hB3C0, 16'hB4C0, 16'hB5C0, 16'hB6C0, 16'hF1C0,
      16'hF2C0, 16'hF3C0, 16'hF4C0, 16'hF5C0, 16'hF6C0, 16'hF9C0, 16'hFAC0,
      16'hE0C5, 16'hE0C6, 16'hE0F9, 16'hE106, 16'hE10B, 16'hEBC0,
      16'hE2E7, 16'hE2E8, 16'hE316, 16'hE320, 16'hE321, 16'hE322,
      16'hE33C, 16'hE33F, 16'hE343, 16'hE345, 16'hE346, 16'hE347, 16'hE360: hit = 1'b1;
      default: begin
        if (v >= 16'hE2A0 && v <= 16'hE2FF)
          hit = (v != 16'hE2A2) && (v != 16'hE2AF) && (v != 16'hE2C0) &&
                (v != 16'hE2E6) && (v != 16'hE2E9) && (v != 16'hE2EA);
        else if (v >= 16'hE300 && v <= 16'hE314) hit = 1'b1;
        else if (v >= 16'hE327 && v <= 16'hE335) hit = 1'b1;
      end
    endcase
    return hit;
  endfunction

  function automatic logic in_set_b(input logic [15:0] v);
    logic hit;
    hit = 1'b0;
    unique case (v)
      16'h0C01, 16'h0C02, 16'h0C03, 16'hA1F9, 16'hA537, 16'hA53B, 16'hA53C,
      16'hA53D, 16'hA53E, 16'hA53F, 16'hA56A, 16'hA56E, 16'hA56F, 16'hA59F: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic code_passes(input logic [31:0] c, input logic en);
    logic ok;
    ok = 1'b0;
    if (!en) ok = 1'b1;
    else begin
      unique case (c[31:24])
        8'hEE: ok = (c[31:16] == 16'hEE00) && (c[15:0] <= 16'h009F);
        8'h00: ok = (c != 32'h0) && (c != 32'h0000ABCD);
        8'hEA: ok = (c[31:16] == 16'hEA00) && in_set_a(c[15:0]);
        8'hB0: ok = in_set_b(c[15:0]);
        8'hDD: ok = (c[31:16] == 16'hDDEE);
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

FILE: design/pcfh_if.sv
// pcfh_in_if / pcfh_out_if: valid-ready channels for items and results
// no dependencies
`timescale 1ns / 1ps
interface pcfh_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] code;
  logic [4:0]  read_limit;
  modport source (output valid, opcode, code, read_limit, input ready);
  modport sink (input valid, opcode, code, read_limit, output ready);
endinterface

interface pcfh_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] entry_value;
  logic        entry_valid;
  logic [4:0]  stored_count;
  logic        last;
  modport source (output valid, accepted, entry_value, entry_valid, stored_count, last,
                  input ready);
  modport sink (input valid, accepted, entry_value, entry_valid, stored_count, last,
                output ready);
endinterface

FILE: design/pcfh_datapath.sv
// pcfh_datapath: filter, history ring, pointers, read counter
// depends on pcfh_pkg
`timescale 1ns / 1ps
module pcfh_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 filter_enable_i,
  input  logic [31:0]          code_i,
  input  logic [4:0]           read_limit_i,
  input  pcfh_pkg::pcfh_cmd_t  cmd_i,
  output pcfh_pkg::pcfh_status_t status_o,
  output logic [31:0]          rd_data_o,
  output logic [4:0]           count_o
);
  import pcfh_pkg::*;

  logic [31:0]     mem [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q, left_q;
  logic [CntW-1:0] n_lim;
  logic            pass;

  assign pass = code_passes(code_i, filter_enable_i);

  always_comb begin
    n_lim = (CntW'(read_limit_i) > cnt_q) ? cnt_q : CntW'(read_limit_i);
    if (n_lim > CntW'(MaxOut)) n_lim = CntW'(MaxOut);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      cnt_q <= '0;
      rp_q <= '0;
      left_q <= '0;
    end else begin
      if (cmd_i.capture && pass) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
        if (cnt_q != CntW'(Depth)) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.read_start) begin
        rp_q <= (wp_q == '0) ? PtrW'(Depth - 1) : wp_q - 1'b1;
        left_q <= n_lim;
      end else if (cmd_i.read_step) begin
        rp_q <= (rp_q == '0) ? PtrW'(Depth - 1) : rp_q - 1'b1;
        left_q <= left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && pass) mem[wp_q] <= code_i;
    if (cmd_i.read_start || cmd_i.read_step)
      rd_data_o <= mem[cmd_i.read_start ? ((wp_q == '0) ? PtrW'(Depth - 1) : wp_q - 1'b1)
                                         : ((rp_q == '0) ? PtrW'(Depth - 1) : rp_q - 1'b1)];
  end

  assign status_o.pass = pass;
  assign status_o.read_empty = (n_lim == '0);
  assign status_o.read_final = (left_q == CntW'(1));
  assign count_o = 5'(cnt_q);
endmodule

FILE: design/pcfh_ctrl.sv
// pcfh_ctrl: sequencer for capture and read, owns the output handshake
// depends on pcfh_pkg
`timescale 1ns / 1ps
module pcfh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_opcode_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_accepted_o,
  output logic                  out_entry_valid_o,
  output logic                  out_last_o,
  output pcfh_pkg::pcfh_cmd_t   cmd_o,
  input  pcfh_pkg::pcfh_status_t status_i
);
  import pcfh_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StOne  = 3'b010,
    StRead = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   acc_q, acc_d, ev_q, ev_d;
  logic   take, pop;

  assign in_ready_o = (state_q == StIdle) || (state_q == StOne && out_ready_i);
  assign take = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = (state_q != StIdle);
  assign out_accepted_o = acc_q;
  assign out_entry_valid_o = ev_q;
  assign out_last_o = (state_q == StOne) || status_i.read_final;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    acc_d = acc_q;
    ev_d = ev_q;
    if (state_q == StRead && pop) begin
      if (status_i.read_final) state_d = StIdle;
      else cmd_o.read_step = 1'b1;
    end else if (state_q == StOne && pop) begin
      state_d = StIdle;
    end
    if (take) begin
      if (in_opcode_i == OpCapture) begin
        cmd_o.capture = 1'b1;
        acc_d = status_i.pass;
        ev_d = 1'b0;
        state_d = StOne;
      end else if (status_i.read_empty) begin
        acc_d = 1'b0;
        ev_d = 1'b0;
        state_d = StOne;
      end else begin
        cmd_o.read_start = 1'b1;
        acc_d = 1'b0;
        ev_d = 1'b1;
        state_d = StRead;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      acc_q <= 1'b0;
      ev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d;
      ev_q <= ev_d;
    end
  end
endmodule

FILE: design/post_code_filter_history_core.sv
// post_code_filter_history_core: top level joining controller and datapath
// depends on pcfh_pkg, pcfh_if, pcfh_ctrl, pcfh_datapath
`timescale 1ns / 1ps
// A capture item gives one result; the next item may enter in the cycle its
// result is taken. A read of n entries gives n results, one per cycle while
// the receiver is ready, from the registered read port of the 16-entry history
// ring; the next item enters in the cycle after the last result is taken.
// stored_count shows the count after the item. filter_enable resets to 1.
module post_code_filter_history_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  pcfh_in_if.sink   in_if,
  pcfh_out_if.source out_if
);
  import pcfh_pkg::*;

  logic         fen_q;
  pcfh_cmd_t    cmd;
  pcfh_status_t status;
  logic [31:0]  rd_data;
  logic [4:0]   count;
  logic         ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fen_q <= 1'b1;
    else if (cfg_we_i) fen_q <= cfg_wdata_i;
  end

  pcfh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_opcode_i(in_if.opcode), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_accepted_o(out_if.accepted), .out_entry_valid_o(ev), .out_last_o(out_if.last),
    .cmd_o(cmd), .status_i(status)
  );

  pcfh_datapath u_dp (
    .clk_i, .rst_ni, .filter_enable_i(fen_q),
    .code_i(in_if.code), .read_limit_i(in_if.read_limit),
    .cmd_i(cmd), .status_o(status), .rd_data_o(rd_data), .count_o(count)
  );

  assign out_if.entry_valid = ev;
  assign out_if.entry_value = ev ? rd_data : 32'h0;
  assign out_if.stored_count = count;
endmodule

FILE: design/pcfh_checker.sv
// pcfh_checker: port-level assertions, bound to the top level
// depends on post_code_filter_history_core
`timescale 1ns / 1ps
module pcfh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic       out_entry_valid,
  input logic       out_last,
  input logic [4:0] out_stored_count
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_stored_count <= 5'd16) else $error("count overflow");
  a_acc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_accepted && out_entry_valid)) else $error("mixed result");
  a_no_take_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready) else $error("item taken mid read");
endmodule

bind post_code_filter_history_core pcfh_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_accepted(out_if.accepted), .out_entry_valid(out_if.entry_valid),
  .out_last(out_if.last), .out_stored_count(out_if.stored_count)
);

FILE: dv/post_code_filter_history_core_test.sv
// post_code_filter_history_core_test: drives capture and read items through the
// post code filter history and checks every result against a local predictor
// depends on pcfh_pkg, pcfh_if and the post_code_filter_history_core rtl
`timescale 1ns / 1ps
module post_code_filter_history_core_test;
  import pcfh_pkg::*;

  typedef struct {
    logic        accepted;
    logic [31:0] entry_value;
    logic        entry_valid;
    logic [4:0]  stored_count;
    logic        last;
  } result_t;

  typedef struct {
    logic        op;
    logic [31:0] code;
    logic [4:0]  lim;
    logic        known;
    logic        acc_exp;
  } row_t;

  localparam logic [15:0] SetA[42] = '{
    16'h0ACE, 16'h0ACF, 16'hBAAB, 16'hBAAC, 16'hBAAD, 16'hE0B5, 16'hE0B6, 16'hE0BC,
    16'hE0BD, 16'hB1C0, 16'hB2C0, 16'hB3C0, 16'hB4C0, 16'hB5C0, 16'hB6C0, 16'hF1C0,
    16'hF2C0, 16'hF3C0, 16'hF4C0, 16'hF5C0, 16'hF6C0, 16'hF9C0, 16'hFAC0, 16'hE0C5,
    16'hE0C6, 16'hE0F9, 16'hE106, 16'hE10B, 16'hEBC0, 16'hE2E7, 16'hE2E8, 16'hE316,
    16'hE320, 16'hE321, 16'hE322, 16'hE33C, 16'hE33F, 16'hE343, 16'hE345, 16'hE346,
    16'hE347, 16'hE360};
  localparam logic [15:0] SetB[14] = '{
    16'h0C01, 16'h0C02, 16'h0C03, 16'hA1F9, 16'hA537, 16'hA53B, 16'hA53C,
    16'hA53D, 16'hA53E, 16'hA53F, 16'hA56A, 16'hA56E, 16'hA56F, 16'hA59F};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  pcfh_in_if in_ch ();
  pcfh_out_if out_ch ();

  post_code_filter_history_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  logic [31:0] ring [Depth];
  logic [3:0]  wr_ptr;
  logic [4:0]  held;
  logic        filt_en;
  result_t     expected_q[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  int          n_accepted = 0;
  bit          hold_off = 0;
  bit          stall_on = 0;
  longint      cycles = 0;

  function automatic bit set_member(logic [15:0] v, bit use_a);
    bit hit;
    hit = 0;
    if (use_a) begin
      foreach (SetA[i]) if (SetA[i] == v) hit = 1;
      if (v >= 16'hE2A0 && v <= 16'hE2FF && v != 16'hE2A2 && v != 16'hE2AF &&
          v != 16'hE2C0 && v != 16'hE2E6 && v != 16'hE2E9 && v != 16'hE2EA) hit = 1;
      if (v >= 16'hE300 && v <= 16'hE314) hit = 1;
      if (v >= 16'hE327 && v <= 16'hE335) hit = 1;
    end else begin
      foreach (SetB[i]) if (SetB[i] == v) hit = 1;
    end
    return hit;
  endfunction

  function automatic bit filter_pass(logic [31:0] c);
    if (!filt_en) return 1;
    case (c[31:24])
      8'hEE: return c[31:16] == 16'hEE00 && c[15:0] <= 16'h009F;
      8'h00: return c != 32'h0 && c != 32'h0000ABCD;
      8'hEA: return c[31:16] == 16'hEA00 && set_member(c[15:0], 1);
      8'hB0: return set_member(c[15:0], 0);
      8'hDD: return c[31:16] == 16'hDDEE;
      default: return 0;
    endcase
  endfunction

  function automatic bit predict_history(logic op, logic [31:0] c, logic [4:0] lim);
    result_t r;
    int n;
    bit ok;
    ok = 0;
    if (op == OpCapture) begin
      ok = filter_pass(c);
      if (ok) begin
        ring[wr_ptr] = c;
        wr_ptr = wr_ptr + 1;
        if (held < Depth) held = held + 1;
      end
      r = '{ok, 32'h0, 1'b0, held, 1'b1};
      expected_q.push_back(r);
    end else begin
      n = lim;
      if (n > held) n = held;
      if (n > MaxOut) n = MaxOut;
      if (n == 0) expected_q.push_back('{1'b0, 32'h0, 1'b0, held, 1'b1});
      for (int i = 0; i < n; i++) begin
        r = '{1'b0, ring[4'(wr_ptr - 1 - i)], 1'b1, held, i == n - 1};
        expected_q.push_back(r);
      end
    end
    return ok;
  endfunction

  // sender
  task automatic send_item(logic op, logic [31:0] c, logic [4:0] lim);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.code <= c;
    in_ch.read_limit <= lim;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    void'(predict_history(op, c, lim));
    n_items++;
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_and_config(logic en);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    filt_en = en;
  endtask

  function automatic logic [31:0] random_code();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 9))
      0: c = {16'hEE00, 16'($urandom_range(0, 16'h00A4))};
      1: c = {8'h00, c[23:0]};
      2: c = {16'hEA00, SetA[$urandom_range(0, $size(SetA) - 1)]};
      3: c = {16'hEA00, 16'($urandom_range(16'hE2A0, 16'hE360))};
      4: c = {8'hB0, c[23:16], SetB[$urandom_range(0, 13)]};
      5: c = {16'hDDEE, c[15:0]};
      6: c = {8'hDD, c[23:0]};
      7: c = {8'hEA, c[23:0]};
      default: ;
    endcase
    return c;
  endfunction

  // receiver stall pattern, with a long hold-off when asked
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    stall_on <= ($urandom_range(0, 15) < 3) ? ~stall_on : stall_on;
    out_ch.ready <= !hold_off && (!stall_on || $urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: entry_value %h", out_ch.entry_value);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.accepted !== e.accepted) begin
          $error("accepted exp %0d got %0d", e.accepted, out_ch.accepted); errors++;
        end
        if (out_ch.entry_value !== e.entry_value) begin
          $error("entry_value exp %h got %h", e.entry_value, out_ch.entry_value); errors++;
        end
        if (out_ch.entry_valid !== e.entry_valid) begin
          $error("entry_valid exp %0d got %0d", e.entry_valid, out_ch.entry_valid); errors++;
        end
        if (out_ch.stored_count !== e.stored_count) begin
          $error("stored_count exp %0d got %0d", e.stored_count, out_ch.stored_count);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_ch.last); errors++;
        end
        if (e.accepted) n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    result_t e;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OpCapture;
    in_ch.code = '0;
    in_ch.read_limit = '0;
    wr_ptr = '0;
    held = '0;
    filt_en = 1'b1;
    foreach (ring[i]) ring[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir = '{
      '{OpRead,    32'h0,        5'd16, 1, 0},
      '{OpRead,    32'h0,        5'd0,  1, 0},
      '{OpCapture, 32'h0,        5'd0,  1, 0},
      '{OpCapture, 32'h0000ABCD, 5'd0,  1, 0},
      '{OpCapture, 32'h00000001, 5'd31, 1, 1},
      '{OpCapture, 32'hFFFFFFFF, 5'd31, 1, 0},
      '{OpCapture, 32'hEE00009F, 5'd0,  1, 1},
      '{OpCapture, 32'hEE0000A0, 5'd0,  1, 0},
      '{OpCapture, 32'hEE01009F, 5'd0,  1, 0},
      '{OpCapture, 32'hEA000ACE, 5'd0,  1, 1},
      '{OpCapture, 32'hEA00EBC0, 5'd0,  1, 1},
      '{OpCapture, 32'hEA00E2C0, 5'd0,  1, 0},
      '{OpCapture, 32'hEA01E360, 5'd0,  1, 0},
      '{OpCapture, 32'hB0FFA59F, 5'd0,  1, 1},
      '{OpCapture, 32'hB0000C04, 5'd0,  1, 0},
      '{OpCapture, 32'hDDEE0000, 5'd0,  1, 1},
      '{OpCapture, 32'hDDEF0000, 5'd0,  1, 0},
      '{OpCapture, 32'h7F000001, 5'd0,  1, 0},
      '{OpRead,    32'hFFFFFFFF, 5'd31, 0, 0},
      '{OpRead,    32'h0,        5'd1,  0, 0}
    };
    foreach (dir[k]) begin
      send_item(dir[k].op, dir[k].code, dir[k].lim);
      e = expected_q[expected_q.size() - 1];
      if (dir[k].known && e.accepted !== dir[k].acc_exp) begin
        $error("table accepted exp %0d pred %0d", dir[k].acc_exp, e.accepted); errors++;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_config(ph % 2 == 1 ? 1'b0 : 1'b1);
      for (int k = 0; k < 78; k++) begin
        if (ph == 2 && k == 10) fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
        if ($urandom_range(0, 3) == 0)
          send_item(OpRead, $urandom, 5'($urandom_range(0, 31)));
        else
          send_item(OpCapture, random_code(), 5'($urandom));
        if ($urandom_range(0, 5) == 0 && !(ph == 2 && k > 10 && k < 40))
          idle_cycles($urandom_range(1, 6));
      end
    end
    drain_and_config(1'b1);
    repeat (20) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d codes accepted", n_items, n_results,
             n_accepted);
    $display("filter on and off, empty, full and wrapped history reads");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pcfh_pkg.sv
design/pcfh_if.sv
design/pcfh_datapath.sv
design/pcfh_ctrl.sv
design/post_code_filter_history_core.sv
design/pcfh_checker.sv
dv/post_code_filter_history_core_test.sv
